/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the escape sequence decoder.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/ced_pkg.sv */
// Package for the C escape sequence decoder: character constants,
// result types and the single-character escape table. No dependencies.
package ced_pkg;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_7   = 8'h37;
  localparam logic [7:0] CH_ALERT     = 8'h07;
  localparam logic [7:0] CH_BSPACE    = 8'h08;
  localparam logic [7:0] CH_FFEED     = 8'h0C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CRETURN   = 8'h0D;
  localparam logic [7:0] CH_HTAB      = 8'h09;
  localparam logic [7:0] CH_VTAB      = 8'h0B;

  // One result item without its last-of-run flag.
  typedef struct packed {
    logic [7:0] data;
    logic       term;
  } res_t;

  // Everything one input byte produces: up to two result items.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } dec_out_t;

  // Escape table: returns {known, character} for the byte after a backslash.
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h22:        r = {1'b1, CH_QUOTE};
      8'h61:        r = {1'b1, CH_ALERT};
      8'h62:        r = {1'b1, CH_BSPACE};
      8'h66:        r = {1'b1, CH_FFEED};
      8'h6E:        r = {1'b1, CH_NEWLINE};
      8'h72:        r = {1'b1, CH_CRETURN};
      8'h74:        r = {1'b1, CH_HTAB};
      8'h76:        r = {1'b1, CH_VTAB};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      default:      r = {1'b0, b};
    endcase
    return r;
  endfunction

endpackage

/* rtl/ced_decode.sv */
// Escape decoder core: mode and octal state plus the combinational
// expansion of one byte into up to two result items. Uses ced_pkg.
module ced_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  output ced_pkg::dec_out_t dec_o
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_OCTAL
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [8:0] oct_val_q, oct_val_d;
  logic [1:0] oct_cnt_q, oct_cnt_d;

  logic       is_oct;
  logic [2:0] digit;
  logic [8:0] oct_next;
  logic [8:0] esc;

  assign is_oct   = (byte_i >= ced_pkg::CH_DIGIT_0) && (byte_i <= ced_pkg::CH_DIGIT_7);
  assign digit    = byte_i[2:0];
  assign oct_next = {oct_val_q[5:0], digit};
  assign esc      = ced_pkg::esc_map(byte_i);

  // Expansion of the current byte according to the decoding mode.
  always_comb begin
    dec_o     = '0;
    mode_d    = mode_q;
    oct_val_d = oct_val_q;
    oct_cnt_d = oct_cnt_q;
    case (mode_q)
      MODE_ESCAPE: begin
        if (byte_i == ced_pkg::CH_NUL) begin
          // Backslash at the end of the string is kept.
          dec_o.count       = 2'd2;
          dec_o.first.data  = ced_pkg::CH_BACKSLASH;
          dec_o.second.data = ced_pkg::CH_NUL;
          dec_o.second.term = 1'b1;
          mode_d            = MODE_NORMAL;
          oct_val_d         = '0;
          oct_cnt_d         = '0;
        end else if (is_oct) begin
          mode_d    = MODE_OCTAL;
          oct_val_d = {6'd0, digit};
          oct_cnt_d = 2'd1;
        end else if (esc[8]) begin
          dec_o.count      = 2'd1;
          dec_o.first.data = esc[7:0];
          mode_d           = MODE_NORMAL;
        end else begin
          // Unknown escape: backslash, then the byte itself.
          dec_o.count       = 2'd2;
          dec_o.first.data  = ced_pkg::CH_BACKSLASH;
          dec_o.second.data = byte_i;
          mode_d            = MODE_NORMAL;
        end
      end
      MODE_OCTAL: begin
        if (is_oct) begin
          if (oct_cnt_q == 2'd2) begin
            // Third digit completes the value.
            dec_o.count      = 2'd1;
            dec_o.first.data = oct_next[7:0];
            mode_d           = MODE_NORMAL;
            oct_val_d        = '0;
            oct_cnt_d        = '0;
          end else begin
            oct_val_d = oct_next;
            oct_cnt_d = oct_cnt_q + 2'd1;
          end
        end else begin
          // Run cut short: flush the value, then copy the byte or, for a backslash, start a new escape.
          dec_o.first.data = oct_val_q[7:0];
          oct_val_d        = '0;
          oct_cnt_d        = '0;
          if (byte_i == ced_pkg::CH_BACKSLASH) begin
            dec_o.count = 2'd1;
            mode_d      = MODE_ESCAPE;
          end else begin
            dec_o.count       = 2'd2;
            dec_o.second.data = byte_i;
            dec_o.second.term = (byte_i == ced_pkg::CH_NUL);
            mode_d            = MODE_NORMAL;
          end
        end
      end
      default: begin
        if (byte_i == ced_pkg::CH_BACKSLASH) begin
          mode_d = MODE_ESCAPE;
        end else begin
          dec_o.count      = 2'd1;
          dec_o.first.data = byte_i;
          dec_o.first.term = (byte_i == ced_pkg::CH_NUL);
          mode_d           = MODE_NORMAL;
          if (byte_i == ced_pkg::CH_NUL) begin
            oct_val_d = '0;
            oct_cnt_d = '0;
          end
        end
      end
    endcase
  end

  // Decoder state advances once per consumed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      oct_val_q <= '0;
      oct_cnt_q <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      oct_val_q <= oct_val_d;
      oct_cnt_q <= oct_cnt_d;
    end
  end

endmodule

/* rtl/ced_outbuf.sv */
// Two-slot result buffer: a head register that drives the output port and
// a pending slot for the second result of an item. Uses ced_pkg.
module ced_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ced_pkg::dec_out_t dec_i,
  output logic              ready_o,
  output logic              pend_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              out_is_terminator_o,
  output logic              out_last_of_run_o
);

  logic          head_vld_q, head_vld_d;
  logic          pend_vld_q, pend_vld_d;
  ced_pkg::res_t head_q, head_d;
  logic          head_last_q, head_last_d;
  ced_pkg::res_t pend_q, pend_d;
  logic          head_free;

  // The head empties this cycle if it is empty or being taken.
  assign head_free = !head_vld_q || !out_stall_i;
  assign ready_o   = head_free && !pend_vld_q;
  assign pend_o    = pend_vld_q;

  // Next contents: load a fresh item, or shift the pending result forward.
  always_comb begin
    head_vld_d  = head_vld_q;
    pend_vld_d  = pend_vld_q;
    head_d      = head_q;
    head_last_d = head_last_q;
    pend_d      = pend_q;
    if (load_i) begin
      head_vld_d  = (dec_i.count != 2'd0);
      head_d      = dec_i.first;
      head_last_d = (dec_i.count == 2'd1);
      pend_vld_d  = (dec_i.count == 2'd2);
      pend_d      = dec_i.second;
    end else if (head_free) begin
      head_vld_d  = pend_vld_q;
      head_d      = pend_q;
      head_last_d = 1'b1;
      pend_vld_d  = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    head_q      <= head_d;
    head_last_q <= head_last_d;
    pend_q      <= pend_d;
  end

  assign out_valid_o         = head_vld_q;
  assign out_byte_o          = head_q.data;
  assign out_is_terminator_o = head_q.term;
  assign out_last_of_run_o   = head_last_q;

endmodule

/* rtl/c_escape_sequence_decoder.sv */
// Streaming C escape sequence decoder. Each input item is one byte of a string, and a
// zero byte ends it. Items pass an input register, are expanded by the decoder and
// land in a two-slot result buffer. Items giving zero or one result are taken at one
// item per cycle while the output does not stall. An item giving two results (unknown
// escape, backslash or cut-short octal run before a byte) holds the input while the
// second result drains from the pending slot.
// Depends on ced_pkg, ced_decode, ced_outbuf and assert_macros.svh.
`include "assert_macros.svh"

module c_escape_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_is_terminator_o,
  output logic       out_last_of_run_o
);

  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              buf_ready;
  logic              buf_pend;
  logic              fire;
  ced_pkg::dec_out_t dec;

  // An item leaves the input register once the buffer can hold its results.
  assign fire       = in_vld_q && buf_ready;
  assign in_stall_o = in_vld_q && !buf_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  ced_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .dec_o  (dec)
  );

  ced_outbuf u_outbuf (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .load_i              (fire),
    .dec_i               (dec),
    .ready_o             (buf_ready),
    .pend_o              (buf_pend),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_byte_o          (out_byte_o),
    .out_is_terminator_o (out_is_terminator_o),
    .out_last_of_run_o   (out_last_of_run_o)
  );

  // A pending second result always sits behind a valid head.
  `ASSERT_NEVER(a_pend_without_head, clk_i, rst_ni, buf_pend && !out_valid_o)
  // A two-result item always fills the pending slot.
  `ASSERT_PROP(a_two_fill_pend, clk_i, rst_ni, (fire && dec.count == 2'd2) |=> buf_pend)
  // A terminator result is a zero byte and closes its run.
  `ASSERT_PROP(a_term_shape, clk_i, rst_ni,
    (out_valid_o && out_is_terminator_o) |-> (out_byte_o == 8'd0 && out_last_of_run_o))
  // A stalled input item is not lost.
  `ASSERT_PROP(a_stall_holds, clk_i, rst_ni, in_stall_o |=> in_vld_q)

endmodule
